// ===== design/smsd_pkg.sv =====
package smsd_pkg;

   localparam int WindowMax  = 64;
   localparam int SampleBits = 16;
   localparam int LenBits    = 7;
   localparam int IdxBits    = $clog2(WindowMax);
   localparam int CountBits  = 24;

   localparam logic [LenBits-1:0]   ResetLength = LenBits'(5);
   localparam logic [CountBits-1:0] CountMax    = {CountBits{1'b1}};

   typedef logic [SampleBits-1:0] sample_type;
   typedef logic [IdxBits-1:0]    age_type;

   // value held by one cell and how many items ago it arrived
   typedef struct packed {
      sample_type value;
      age_type    age;
   } cell_state_type;

   // compacted entry handed up the chain, with its compare against the new item
   typedef struct packed {
      sample_type value;
      age_type    age;
      logic       gt;
   } cell_link_type;

   // broadcast to every cell for the item in flight
   typedef struct packed {
      sample_type sample;
      logic       update;
      logic       full;
      age_type    last_age;
   } cell_ctl_type;

endpackage

// ===== design/smsd_cell.sv =====
module smsd_cell (
   input  logic                     clock,
   input  smsd_pkg::cell_ctl_type   ctl,
   input  logic                     held,
   input  logic                     shift_up,
   input  logic                     keep_valid,
   input  smsd_pkg::cell_link_type  prev_link,
   input  smsd_pkg::cell_state_type next_state,
   output smsd_pkg::cell_state_type state,
   output smsd_pkg::cell_link_type  link,
   output logic                     retire
);
   import smsd_pkg::*;

   cell_state_type state_ff;
   cell_state_type state_in;
   cell_state_type comp;

   assign state  = state_ff;
   assign retire = ctl.full && held && (state_ff.age == ctl.last_age);

   // entry at this position once the retiring one is squeezed out
   assign comp = shift_up ? next_state : state_ff;

   assign link.value = comp.value;
   assign link.age   = comp.age;
   assign link.gt    = !keep_valid || (comp.value > ctl.sample);

   always_comb begin
      priority if (prev_link.gt) begin
         state_in.value = prev_link.value;
         state_in.age   = prev_link.age + age_type'(1);
      end else if (link.gt) begin
         state_in.value = ctl.sample;
         state_in.age   = '0;
      end else begin
         state_in.value = comp.value;
         state_in.age   = comp.age + age_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.update) begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/sliding_median_spike_detector_core.sv =====
// Sliding-window median spike detector. Each item carries one sample and
// returns one result: flagged when a full window of the last d samples
// preceded it and the sample is at least the sum of the two middle sorted
// entries (twice the middle one for odd d), plus a saturating flag count.
// The sorted window lives in a row of 64 cells; each item is compared in
// every cell in parallel, the oldest entry retires and the new one drops
// into place in the same cycle, so one item is taken per clock unless a
// stalled response holds it, and each result is registered. A write of
// window_length (0 as 1, over 64 as 64) empties it but keeps the flag count.
module sliding_median_spike_detector_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [smsd_pkg::SampleBits-1:0]     req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_flagged,
   output logic                                rsp_window_ready,
   output logic [smsd_pkg::CountBits-1:0]      rsp_flag_count,
   input  logic                                csr_write_enable,
   input  logic [smsd_pkg::LenBits-1:0]        csr_write_data
);
   import smsd_pkg::*;

   logic [LenBits-1:0]   length_ff;
   logic [LenBits-1:0]   fill_ff, fill_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 flagged_ff, ready_ff;
   logic [CountBits-1:0] rsp_count_ff;

   logic [LenBits-1:0]   d_eff;
   logic [LenBits-1:0]   held_n;
   logic [LenBits-1:0]   comp_n;
   logic                 full;
   logic                 accept;
   logic                 flag;
   age_type              lo_idx, hi_idx;
   sample_type           mid_lo, mid_hi;
   logic [SampleBits:0]  threshold;
   logic [LenBits-1:0]   d_minus;

   cell_ctl_type         ctl;
   cell_state_type       cell_state [WindowMax];
   cell_link_type        cell_link  [WindowMax];
   cell_link_type        prev_link  [WindowMax];
   cell_state_type       next_state [WindowMax];
   logic [WindowMax-1:0] retire, held, shift_up, keep_valid;

   always_comb begin
      priority if (length_ff == '0) begin
         d_eff = LenBits'(1);
      end else if (length_ff > LenBits'(WindowMax)) begin
         d_eff = LenBits'(WindowMax);
      end else begin
         d_eff = length_ff;
      end
   end

   assign full    = fill_ff >= d_eff;
   assign held_n  = full ? d_eff : fill_ff;
   assign comp_n  = full ? (d_eff - LenBits'(1)) : fill_ff;
   assign d_minus = d_eff - LenBits'(1);
   assign lo_idx  = d_minus[IdxBits:1];
   assign hi_idx  = IdxBits'(d_eff >> 1);

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign ctl.sample   = req_sample;
   assign ctl.update   = accept;
   assign ctl.full     = full;
   assign ctl.last_age = d_minus[IdxBits-1:0];

   // every cell at or above the retiring one takes its upper neighbor
   always_comb begin
      logic seen;
      seen = 1'b0;
      for (int i = 0; i < WindowMax; i++) begin
         seen        = seen | retire[i];
         shift_up[i] = seen;
      end
   end

   for (genvar g = 0; g < WindowMax; g++) begin : g_cell
      assign held[g]       = LenBits'(g) < held_n;
      assign keep_valid[g] = LenBits'(g) < comp_n;

      if (g == 0) begin : g_first
         assign prev_link[g] = '0;
      end else begin : g_rest
         assign prev_link[g] = cell_link[g-1];
      end

      if (g == WindowMax - 1) begin : g_last
         assign next_state[g] = '0;
      end else begin : g_inner
         assign next_state[g] = cell_state[g+1];
      end

      smsd_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .held       (held[g]),
         .shift_up   (shift_up[g]),
         .keep_valid (keep_valid[g]),
         .prev_link  (prev_link[g]),
         .next_state (next_state[g]),
         .state      (cell_state[g]),
         .link       (cell_link[g]),
         .retire     (retire[g])
      );
   end

   // pick the two middle entries; they coincide for odd d
   always_comb begin
      mid_lo = '0;
      mid_hi = '0;
      for (int i = 0; i < WindowMax; i++) begin
         mid_lo = mid_lo | (cell_state[i].value & {SampleBits{lo_idx == IdxBits'(i)}});
         mid_hi = mid_hi | (cell_state[i].value & {SampleBits{hi_idx == IdxBits'(i)}});
      end
   end

   assign threshold = {1'b0, mid_lo} + {1'b0, mid_hi};
   assign flag      = full && ({1'b0, req_sample} >= threshold);

   always_comb begin
      fill_in      = fill_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
         if (!full) begin
            fill_in = fill_ff + LenBits'(1);
         end
         if (flag && count_ff != CountMax) begin
            count_in = count_ff + CountBits'(1);
         end
      end
      if (csr_write_enable) begin
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= ResetLength;
         fill_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            length_ff <= csr_write_data;
         end
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         flagged_ff   <= flag;
         ready_ff     <= full;
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_flagged      = flagged_ff;
   assign rsp_window_ready = ready_ff;
   assign rsp_flag_count   = rsp_count_ff;

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= LenBits'(WindowMax))
      else $error("fill level beyond window size");

   a_one_retire: assert property (@(posedge clock) disable iff (reset)
      (accept && full) |-> $onehot(retire))
      else $error("full window without exactly one oldest entry");

   a_count_mono: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> (count_ff >= $past(count_ff)))
      else $error("flag count went backwards");

   a_flag_needs_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_flagged) |-> rsp_window_ready)
      else $error("item flagged without a full window");
`endif

endmodule
